### hdl/mpeg1_audio_frame_cutter_macros.svh
// ---------------------------------------------------------------------------
// MPEG-1 audio frame cutter assertion macros
// Concurrent property macros clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MPEG1_AUDIO_FRAME_CUTTER_MACROS_SVH
`define MPEG1_AUDIO_FRAME_CUTTER_MACROS_SVH

// same-cycle implication
`define MFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mfc_pkg.sv
// ---------------------------------------------------------------------------
// mfc_pkg
// Constants, types and header decode tables of the MPEG-1 audio frame cutter.
// ---------------------------------------------------------------------------
package mfc_pkg;

    localparam int BLOCKS_PER_SECOND = 75;
    localparam int FRAME_SAMPLES     = 1152;

    localparam int CNT_W   = 32;
    localparam int BLK_W   = 24;
    localparam int HZ_W    = 16;
    localparam int KBPS_W  = 9;
    localparam int SIZE_W  = 11;
    localparam int MUL_A_W = CNT_W + 1;
    localparam int MUL_B_W = HZ_W;
    localparam int BPS_W   = $clog2(BLOCKS_PER_SECOND + 1);
    localparam int PROD_W  = (MUL_A_W + BPS_W > BLK_W + HZ_W) ? MUL_A_W + BPS_W
                                                               : BLK_W + HZ_W;

    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic REG_START_BLOCK = 1'b0;
    localparam logic REG_END_BLOCK   = 1'b1;

    localparam logic [10:0] SYNC_WORD    = 11'h7ff;
    localparam logic [1:0]  VER_MPEG1    = 2'd3;
    localparam logic [1:0]  LAYER_III    = 2'd1;
    localparam logic [1:0]  LAYER_II     = 2'd2;
    localparam logic [3:0]  BRI_FREE     = 4'd0;
    localparam logic [3:0]  BRI_BAD      = 4'd15;
    localparam logic [1:0]  SRI_44K1     = 2'd0;
    localparam logic [1:0]  SRI_48K      = 2'd1;
    localparam logic [1:0]  SRI_32K      = 2'd2;

    typedef struct packed {
        logic [BLK_W-1:0] start_block;
        logic [BLK_W-1:0] end_block;
    } t_cfg;

    function automatic logic [KBPS_W-1:0] kbps_of(input logic [1:0] layer,
                                                  input logic [3:0] bri);
        logic [KBPS_W-1:0] k;
        if (layer == LAYER_III) begin
            case (bri)
                4'd1:    k = 9'd32;
                4'd2:    k = 9'd40;
                4'd3:    k = 9'd48;
                4'd4:    k = 9'd56;
                4'd5:    k = 9'd64;
                4'd6:    k = 9'd80;
                4'd7:    k = 9'd96;
                4'd8:    k = 9'd112;
                4'd9:    k = 9'd128;
                4'd10:   k = 9'd160;
                4'd11:   k = 9'd192;
                4'd12:   k = 9'd224;
                4'd13:   k = 9'd256;
                4'd14:   k = 9'd320;
                default: k = 9'd0;
            endcase
        end else begin
            case (bri)
                4'd1:    k = 9'd32;
                4'd2:    k = 9'd48;
                4'd3:    k = 9'd56;
                4'd4:    k = 9'd64;
                4'd5:    k = 9'd80;
                4'd6:    k = 9'd96;
                4'd7:    k = 9'd112;
                4'd8:    k = 9'd128;
                4'd9:    k = 9'd160;
                4'd10:   k = 9'd192;
                4'd11:   k = 9'd224;
                4'd12:   k = 9'd256;
                4'd13:   k = 9'd320;
                4'd14:   k = 9'd384;
                default: k = 9'd0;
            endcase
        end
        return k;
    endfunction

    function automatic logic [HZ_W-1:0] rate_hz(input logic [1:0] sri);
        logic [HZ_W-1:0] hz;
        case (sri)
            SRI_44K1: hz = 16'd44100;
            SRI_48K:  hz = 16'd48000;
            SRI_32K:  hz = 16'd32000;
            default:  hz = 16'd0;
        endcase
        return hz;
    endfunction

    // floor(144000 * kbps / hz), padding not included
    function automatic logic [SIZE_W-1:0] frame_bytes(input logic [KBPS_W-1:0] k,
                                                      input logic [1:0] sri);
        logic [12:0]       t9;
        logic [SIZE_W-1:0] s;
        t9 = 13'(k) * 13'd9;
        case (sri)
            SRI_48K: s = 11'(k) * 11'd3;
            SRI_32K: s = t9[11:1];
            SRI_44K1: begin
                case (k)
                    9'd32:   s = 11'd104;
                    9'd40:   s = 11'd130;
                    9'd48:   s = 11'd156;
                    9'd56:   s = 11'd182;
                    9'd64:   s = 11'd208;
                    9'd80:   s = 11'd261;
                    9'd96:   s = 11'd313;
                    9'd112:  s = 11'd365;
                    9'd128:  s = 11'd417;
                    9'd160:  s = 11'd522;
                    9'd192:  s = 11'd626;
                    9'd224:  s = 11'd731;
                    9'd256:  s = 11'd835;
                    9'd320:  s = 11'd1044;
                    9'd384:  s = 11'd1253;
                    default: s = 11'd0;
                endcase
            end
            default: s = 11'd0;
        endcase
        return s;
    endfunction

endpackage

### hdl/mpeg1_audio_frame_cutter.sv
// ---------------------------------------------------------------------------
// mpeg1_audio_frame_cutter
// Finds MPEG-1 Layer II/III frames in a byte stream and copies the frames
// that fall inside the configured start/end time window.
// ---------------------------------------------------------------------------
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_byte
// out       output     o_out_valid / i_out_ready  o_out_byte, o_frame_first,
//                                                 o_cut_last, o_run_last
// cfg       APB        psel, penable, pwrite      paddr, pwdata, prdata
//
// Body, junk and non-header bytes are taken in ST_IDLE; copied body bytes then pass
// through the output register. Valid header: states ST_M0 to ST_M4 form four products
// on the shared multiplier and compare them, then ST_EMIT sends the header bytes if copied.
// o_in_ready is low while the sequence runs or an output item is held.
// A stall on the output holds the item; reset is synchronous, active low.
// ---------------------------------------------------------------------------
module mpeg1_audio_frame_cutter
    import mfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_frame_first,
    output logic              o_cut_last,
    output logic              o_run_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M0   = 3'd1;
    localparam logic [2:0] ST_M1   = 3'd2;
    localparam logic [2:0] ST_M2   = 3'd3;
    localparam logic [2:0] ST_M3   = 3'd4;
    localparam logic [2:0] ST_M4   = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    t_cfg w_cfg;

    logic [2:0]        r_state,    n_state;
    logic [23:0]       r_window,   n_window;
    logic [SIZE_W-1:0] r_body,     n_body;
    logic              r_sel,      n_sel;
    logic              r_final,    n_final;
    logic              r_finished, n_finished;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic [31:0]       r_hdr,      n_hdr;
    logic [1:0]        r_sri,      n_sri;
    logic [1:0]        r_idx,      n_idx;
    logic [PROD_W-1:0] r_pa,       n_pa;
    logic              r_ovalid,   n_ovalid;
    logic [7:0]        r_obyte,    n_obyte;
    logic              r_ofirst,   n_ofirst;
    logic              r_ocut,     n_ocut;
    logic              r_orun,     n_orun;

    logic [31:0]        w_hdr;
    logic               w_hdr_ok;
    logic [SIZE_W-1:0]  w_size;
    logic               w_in_acc;
    logic               w_out_free;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W:0]    w_prod_top;
    logic [MUL_A_W-1:0] w_cnt_plus;
    logic [HZ_W-1:0]    w_hz;
    logic               w_endhere;
    logic [7:0]         w_emit_byte;

    mfc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mfc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_hdr      = {r_window, i_in_byte};
    assign w_hdr_ok   = (w_hdr[31:21] == SYNC_WORD) && (w_hdr[20:19] == VER_MPEG1) &&
                        ((w_hdr[18:17] == LAYER_III) || (w_hdr[18:17] == LAYER_II)) &&
                        (w_hdr[15:12] != BRI_FREE) && (w_hdr[15:12] != BRI_BAD) &&
                        (w_hdr[11:10] != 2'd3);
    assign w_size     = frame_bytes(kbps_of(w_hdr[18:17], w_hdr[15:12]), w_hdr[11:10]) +
                        SIZE_W'(w_hdr[9]);
    assign o_in_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_hz       = rate_hz(r_sri);
    assign w_cnt_plus = {1'b0, r_count} + MUL_A_W'(FRAME_SAMPLES);
    assign w_prod_top = {1'b0, w_prod} + (PROD_W+1)'(BLOCKS_PER_SECOND - 1);
    assign w_endhere  = (r_body == '0) && r_final;
    assign w_emit_byte = 8'(r_hdr >> {~r_idx, 3'b000});

    // multiplier operand select; product arrives in the next state
    always_comb begin
        case (r_state)
            ST_M0: begin
                w_mul_a = MUL_A_W'(w_cfg.start_block);
                w_mul_b = w_hz;
            end
            ST_M1: begin
                w_mul_a = {1'b0, r_count};
                w_mul_b = MUL_B_W'(BLOCKS_PER_SECOND);
            end
            ST_M2: begin
                w_mul_a = MUL_A_W'(w_cfg.end_block);
                w_mul_b = w_hz;
            end
            ST_M3: begin
                w_mul_a = w_cnt_plus;
                w_mul_b = MUL_B_W'(BLOCKS_PER_SECOND);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_window   = r_window;
        n_body     = r_body;
        n_sel      = r_sel;
        n_final    = r_final;
        n_finished = r_finished;
        n_count    = r_count;
        n_hdr      = r_hdr;
        n_sri      = r_sri;
        n_idx      = r_idx;
        n_pa       = r_pa;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_obyte    = r_obyte;
        n_ofirst   = r_ofirst;
        n_ocut     = r_ocut;
        n_orun     = r_orun;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && !r_finished) begin
                    if (r_body != '0) begin
                        n_body = r_body - 1'b1;
                        if (r_sel) begin
                            n_ovalid = 1'b1;
                            n_obyte  = i_in_byte;
                            n_ofirst = 1'b0;
                            n_ocut   = (r_body == SIZE_W'(1)) && r_final;
                            n_orun   = 1'b1;
                            if ((r_body == SIZE_W'(1)) && r_final) begin
                                n_finished = 1'b1;
                            end
                        end
                    end else if (w_hdr_ok) begin
                        n_hdr    = w_hdr;
                        n_window = '0;
                        n_body   = w_size - SIZE_W'(4);
                        n_sri    = w_hdr[11:10];
                        n_state  = ST_M0;
                    end else begin
                        n_window = w_hdr[23:0];
                    end
                end
            end
            ST_M0: n_state = ST_M1;
            ST_M1: begin
                n_pa    = w_prod;
                n_state = ST_M2;
            end
            ST_M2: begin
                n_sel   = {1'b0, r_pa} <= w_prod_top;
                n_state = ST_M3;
            end
            ST_M3: begin
                n_pa    = w_prod;
                n_state = ST_M4;
            end
            ST_M4: begin
                n_final = r_sel && (r_pa >= PROD_W'(BLOCKS_PER_SECOND)) &&
                          ({1'b0, r_pa} <= w_prod_top);
                n_count = w_cnt_plus[CNT_W] ? '1 : w_cnt_plus[CNT_W-1:0];
                n_idx   = '0;
                n_state = r_sel ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = w_emit_byte;
                    n_ofirst = (r_idx == 2'd0);
                    n_ocut   = (r_idx == 2'd3) && w_endhere;
                    n_orun   = (r_idx == 2'd3);
                    n_idx    = r_idx + 1'b1;
                    if (r_idx == 2'd3) begin
                        n_state = ST_IDLE;
                        if (w_endhere) begin
                            n_finished = 1'b1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_window   <= '0;
            r_body     <= '0;
            r_sel      <= 1'b0;
            r_final    <= 1'b0;
            r_finished <= 1'b0;
            r_count    <= '0;
            r_idx      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_window   <= n_window;
            r_body     <= n_body;
            r_sel      <= n_sel;
            r_final    <= n_final;
            r_finished <= n_finished;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr    <= n_hdr;
        r_sri    <= n_sri;
        r_pa     <= n_pa;
        r_obyte  <= n_obyte;
        r_ofirst <= n_ofirst;
        r_ocut   <= n_ocut;
        r_orun   <= n_orun;
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_frame_first = r_ofirst;
    assign o_cut_last    = r_ocut;
    assign o_run_last    = r_orun;

endmodule

### hdl/mfc_apb_regs.sv
// ---------------------------------------------------------------------------
// mfc_apb_regs
// APB register file holding the cut start and end times.
// ---------------------------------------------------------------------------
module mfc_apb_regs
    import mfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [BLK_W-1:0] r_start_block, n_start_block;
    logic [BLK_W-1:0] r_end_block,   n_end_block;
    logic             w_wr;
    logic             w_sel_reg;

    // low address bits do not select a register
    assign w_sel_reg = paddr[2];
    assign w_wr      = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        n_start_block = r_start_block;
        n_end_block   = r_end_block;
        if (w_wr) begin
            case (w_sel_reg)
                REG_START_BLOCK: n_start_block = pwdata[BLK_W-1:0];
                REG_END_BLOCK:   n_end_block   = pwdata[BLK_W-1:0];
                default:         n_start_block = r_start_block;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_block <= '0;
            r_end_block   <= '0;
        end else begin
            r_start_block <= n_start_block;
            r_end_block   <= n_end_block;
        end
    end

    always_comb begin
        case (w_sel_reg)
            REG_START_BLOCK: prdata = DATA_W'(r_start_block);
            REG_END_BLOCK:   prdata = DATA_W'(r_end_block);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.start_block = r_start_block;
    assign o_cfg.end_block   = r_end_block;

endmodule

### hdl/mfc_mul.sv
// ---------------------------------------------------------------------------
// mfc_mul
// Shared registered multiplier used for all sample-target products.
// ---------------------------------------------------------------------------
module mfc_mul
    import mfc_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [PROD_W-1:0]  o_prod
);

    logic [MUL_A_W+MUL_B_W-1:0] w_full;
    logic [PROD_W-1:0]          r_prod;

    assign w_full = {{MUL_B_W{1'b0}}, i_a} * {{MUL_A_W{1'b0}}, i_b};

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

### hdl/mfc_checker.sv
// ---------------------------------------------------------------------------
// mfc_checker
// Port-level checks of the frame cutter, bound to the top level.
// ---------------------------------------------------------------------------
`include "mpeg1_audio_frame_cutter_macros.svh"

module mfc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_frame_first,
    input logic i_cut_last,
    input logic i_run_last
);

    `MFC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "output item dropped while stalled")
    `MFC_ASSERT_NOW(a_no_take_while_held, i_out_valid, !i_in_ready, "input taken while an output item is held")
    `MFC_ASSERT_NOW(a_first_not_last, i_out_valid && i_frame_first, !i_run_last && !i_cut_last, "first header byte marked last")
    `MFC_ASSERT_NOW(a_cut_ends_run, i_out_valid && i_cut_last, i_run_last, "cut end not on last item of its byte")
    `MFC_ASSERT_NEXT(a_silent_after_cut, i_out_valid && i_out_ready && i_cut_last, !i_out_valid, "output after the end of the cut")

endmodule

bind mpeg1_audio_frame_cutter mfc_checker u_mfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (o_in_ready),
    .i_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .i_frame_first (o_frame_first),
    .i_cut_last    (o_cut_last),
    .i_run_last    (o_run_last)
);

### tb/mpeg1_audio_frame_cutter_test.sv
// ---------------------------------------------------------------------------
// mpeg1_audio_frame_cutter_test
// Feeds byte streams of MPEG-1 Layer II/III frames, junk, broken headers and
// cut-short frames into the cutter, with random gaps on both channels. The
// cut_tracker class follows the header search, frame selection and sample
// count, and checks every output item in order. Start and end registers are
// rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpeg1_audio_frame_cutter_test;
    import mfc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [1:0] VER_MPEG2  = 2'd2;
    localparam logic [1:0] LAYER_I    = 2'd3;
    localparam logic [1:0] LAYER_RSVD = 2'd0;
    localparam logic [1:0] SRI_RSVD   = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       cut_end;
        logic       run_end;
    } cut_byte_t;

    class cut_tracker;
        logic [BLK_W-1:0]  start_blk;
        logic [BLK_W-1:0]  end_blk;
        logic [23:0]       window;
        logic [SIZE_W-1:0] body_left;
        logic              selected;
        logic              final_frm;
        logic              done;
        logic [CNT_W-1:0]  samples;
        cut_byte_t         due_q[$];
        int                errors;
        int                checked;
        int unsigned kbps_l2[16] = '{0, 32, 48, 56, 64, 80, 96, 112,
                                     128, 160, 192, 224, 256, 320, 384, 0};
        int unsigned kbps_l3[16] = '{0, 32, 40, 48, 56, 64, 80, 96,
                                     112, 128, 160, 192, 224, 256, 320, 0};

        function new();
            start_blk = '0;
            end_blk   = '0;
            window    = '0;
            body_left = '0;
            selected  = 1'b0;
            final_frm = 1'b0;
            done      = 1'b0;
            samples   = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void set_reg(logic idx, logic [BLK_W-1:0] value);
            if (idx == REG_START_BLOCK)
                start_blk = value;
            else
                end_blk = value;
        endfunction

        function int unsigned rate_of(logic [1:0] sri);
            case (sri)
                SRI_44K1: return 44100;
                SRI_48K:  return 48000;
                SRI_32K:  return 32000;
                default:  return 0;
            endcase
        endfunction

        function int frame_len(logic [1:0] layer, logic [3:0] bri, logic [1:0] sri,
                               logic pad);
            longint unsigned kb;
            kb = (layer == LAYER_III) ? kbps_l3[bri] : kbps_l2[bri];
            return int'(64'(144000) * kb / 64'(rate_of(sri))) + int'(pad);
        endfunction

        function void add_due(logic [7:0] data, logic first, logic cut_end, logic run_end);
            cut_byte_t c;
            c.data    = data;
            c.first   = first;
            c.cut_end = cut_end;
            c.run_end = run_end;
            due_q.push_back(c);
        endfunction

        function void take_byte(logic [7:0] b);
            logic [31:0]     hdr;
            logic [1:0]      layer;
            logic [1:0]      sri;
            logic [3:0]      bri;
            longint unsigned hz;
            longint unsigned start_s;
            longint unsigned end_s;
            if (done)
                return;
            if (body_left != 0) begin
                body_left--;
                if (!selected)
                    return;
                if (body_left == 0 && final_frm)
                    done = 1'b1;
                add_due(b, 1'b0, done, 1'b1);
                return;
            end
            hdr    = {window, b};
            window = hdr[23:0];
            layer  = hdr[18:17];
            bri    = hdr[15:12];
            sri    = hdr[11:10];
            if (hdr[31:21] != SYNC_WORD || hdr[20:19] != VER_MPEG1 ||
                !(layer == LAYER_II || layer == LAYER_III) ||
                bri == BRI_FREE || bri == BRI_BAD || sri == SRI_RSVD)
                return;
            hz        = rate_of(sri);
            window    = '0;
            body_left = SIZE_W'(frame_len(layer, bri, sri, hdr[9]) - 4);
            start_s   = 64'(start_blk) * hz / 64'(BLOCKS_PER_SECOND);
            end_s     = 64'(end_blk) * hz / 64'(BLOCKS_PER_SECOND);
            selected  = start_s <= 64'(samples);
            final_frm = selected && end_s != 0 &&
                        end_s <= 64'(samples) + 64'(FRAME_SAMPLES);
            if (samples > 32'hFFFF_FFFF - 32'(FRAME_SAMPLES))
                samples = 32'hFFFF_FFFF;
            else
                samples = samples + 32'(FRAME_SAMPLES);
            if (!selected)
                return;
            if (body_left == 0 && final_frm)
                done = 1'b1;
            add_due(hdr[31:24], 1'b1, 1'b0, 1'b0);
            add_due(hdr[23:16], 1'b0, 1'b0, 1'b0);
            add_due(hdr[15:8], 1'b0, 1'b0, 1'b0);
            add_due(hdr[7:0], 1'b0, done, 1'b1);
        endfunction

        function void check_byte(logic [7:0] data, logic first, logic cut_end,
                                 logic run_end);
            cut_byte_t want;
            if (due_q.size() == 0) begin
                flag($sformatf("unexpected output %02h first %b cut_last %b run_last %b",
                               data, first, cut_end, run_end));
                return;
            end
            want = due_q.pop_front();
            if (data !== want.data || first !== want.first ||
                cut_end !== want.cut_end || run_end !== want.run_end)
                flag($sformatf({"output %0d: expected %02h first %b cut_last %b ",
                                "run_last %b, got %02h %b %b %b"}, checked,
                               want.data, want.first, want.cut_end, want.run_end,
                               data, first, cut_end, run_end));
            checked++;
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_in_byte = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [7:0]        o_out_byte;
    logic              o_frame_first;
    logic              o_cut_last;
    logic              o_run_last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    cut_tracker  sb;
    logic [7:0]  stream_q[$];
    int          send_idle_pct = 16;
    int          recv_stall_pct = 56;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          cycle_cnt = 0;

    mpeg1_audio_frame_cutter u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // output side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_byte(o_out_byte, o_frame_first, o_cut_last, o_run_last);
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [31:0] hdr_word(logic [10:0] sync, logic [1:0] ver,
                                             logic [1:0] layer, logic [3:0] bri,
                                             logic [1:0] sri, logic pad);
        logic [31:0] w;
        w        = $urandom;
        w[31:21] = sync;
        w[20:19] = ver;
        w[18:17] = layer;
        w[15:12] = bri;
        w[11:10] = sri;
        w[9]     = pad;
        return w;
    endfunction

    function automatic void push_word(logic [31:0] w);
        stream_q.push_back(w[31:24]);
        stream_q.push_back(w[23:16]);
        stream_q.push_back(w[15:8]);
        stream_q.push_back(w[7:0]);
    endfunction

    // keep < 0: whole body; hide: body opens with a valid-looking header
    function automatic void push_frame(logic [1:0] layer, logic [3:0] bri, logic [1:0] sri,
                                       logic pad, int keep, logic hide);
        int body;
        body = sb.frame_len(layer, bri, sri, pad) - 4;
        if (keep >= 0 && keep < body)
            body = keep;
        push_word(hdr_word(SYNC_WORD, VER_MPEG1, layer, bri, sri, pad));
        if (hide && body >= 4) begin
            push_word(hdr_word(SYNC_WORD, VER_MPEG1, LAYER_II, 4'd1, SRI_48K, 1'b0));
            body -= 4;
        end
        for (int k = 0; k < body; k++)
            stream_q.push_back(8'($urandom));
    endfunction

    function automatic void push_random_item();
        logic [1:0]  layer;
        logic [1:0]  sri;
        logic [3:0]  bri;
        logic        pad;
        logic [31:0] w;
        int          body;
        int          pick;
        pick  = $urandom_range(99);
        layer = $urandom_range(1) ? LAYER_II : LAYER_III;
        case ($urandom_range(2))
            0:       sri = SRI_44K1;
            1:       sri = SRI_48K;
            default: sri = SRI_32K;
        endcase
        bri  = ($urandom_range(19) == 0) ? 4'($urandom_range(14, 1))
                                         : 4'($urandom_range(3, 1));
        pad  = 1'($urandom_range(1));
        body = sb.frame_len(layer, bri, sri, pad) - 4;
        if (pick < 10) begin
            repeat ($urandom_range(8, 1)) stream_q.push_back(8'($urandom));
        end else if (pick < 18) begin
            w = hdr_word(SYNC_WORD, VER_MPEG1, layer, bri, sri, pad);
            case ($urandom_range(4))
                0:       w[20:19] = 2'($urandom_range(2));
                1:       w[18:17] = $urandom_range(1) ? LAYER_I : LAYER_RSVD;
                2:       w[15:12] = $urandom_range(1) ? BRI_FREE : BRI_BAD;
                3:       w[11:10] = SRI_RSVD;
                default: w[21 + $urandom_range(10)] = 1'b0;
            endcase
            push_word(w);
        end else if (pick < 28) begin
            push_frame(layer, bri, sri, pad, int'($urandom_range(body - 1)), 1'b0);
        end else begin
            push_frame(layer, bri, sri, pad, -1, $urandom_range(4) == 0);
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) stream_q.push_back(8'($urandom));
    endfunction

    function automatic logic [BLK_W-1:0] blocks_ahead(int frames);
        return BLK_W'((64'(sb.samples) + 64'(frames * FRAME_SAMPLES)) *
                      64'(BLOCKS_PER_SECOND) / 64'(48000) + 1);
    endfunction

    task automatic apb_xfer(input logic wr, input logic idx, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic write_reg(input logic idx, input logic [BLK_W-1:0] value);
        logic [DATA_W-1:0] rd;
        apb_xfer(1'b1, idx, DATA_W'(value), rd);
        sb.set_reg(idx, value);
        apb_xfer(1'b0, idx, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[BLK_W-1:0] !== value)
            sb.flag($sformatf("register %0d: wrote %06h, read %06h", idx, value,
                              rd[BLK_W-1:0]));
    endtask

    task automatic send_stream(input int unsigned leave);
        logic [7:0] b;
        while (stream_q.size() > leave) begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            b = stream_q.pop_front();
            i_in_valid <= 1'b1;
            i_in_byte  <= b;
            do @(posedge i_clk); while (!o_in_ready);
            sb.take_byte(b);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int items, input int unsigned leave);
        repeat (items) push_random_item();
        send_stream(leave);
        wait_idle();
    endtask

    initial begin
        logic [BLK_W-1:0] cut_start;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(REG_START_BLOCK, '0);
        write_reg(REG_END_BLOCK, '0);

        // directed: extremes, every rejected header field, frame corner cases
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        push_word(hdr_word(SYNC_WORD, VER_MPEG2, LAYER_II, 4'd1, SRI_48K, 1'b0));
        push_word(hdr_word(SYNC_WORD, VER_MPEG1, LAYER_I, 4'd1, SRI_48K, 1'b0));
        push_word(hdr_word(SYNC_WORD, VER_MPEG1, LAYER_RSVD, 4'd1, SRI_48K, 1'b0));
        push_word(hdr_word(SYNC_WORD, VER_MPEG1, LAYER_II, BRI_FREE, SRI_48K, 1'b0));
        push_word(hdr_word(SYNC_WORD, VER_MPEG1, LAYER_III, BRI_BAD, SRI_44K1, 1'b0));
        push_word(hdr_word(SYNC_WORD, VER_MPEG1, LAYER_II, 4'd1, SRI_RSVD, 1'b0));
        push_word(hdr_word(SYNC_WORD ^ 11'h001, VER_MPEG1, LAYER_II, 4'd1, SRI_48K, 1'b0));
        push_frame(LAYER_II, 4'd1, SRI_48K, 1'b0, -1, 1'b0);
        stream_q.push_back(8'hFF);
        push_frame(LAYER_III, 4'd1, SRI_44K1, 1'b1, -1, 1'b1);
        push_frame(LAYER_II, 4'd2, SRI_32K, 1'b0, 40, 1'b0);
        push_frame(LAYER_III, 4'd3, SRI_48K, 1'b0, -1, 1'b0);
        push_frame(LAYER_III, 4'd14, SRI_48K, 1'b0, -1, 1'b0);
        push_frame(LAYER_II, 4'd14, SRI_32K, 1'b1, -1, 1'b0);
        send_stream(0);
        wait_idle();

        // long output hold while input bytes keep being offered
        hold_reqs++;
        run_phase(10, $urandom_range(40));

        write_reg(REG_START_BLOCK, '1);
        run_phase(4, $urandom_range(40));

        send_idle_pct  = 56;
        recv_stall_pct = 16;
        write_reg(REG_START_BLOCK, blocks_ahead(2));
        write_reg(REG_END_BLOCK, '1);
        run_phase(10, $urandom_range(40));

        // last phase: cut ends, later bytes are ignored
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cut_start = blocks_ahead(2);
        write_reg(REG_START_BLOCK, cut_start);
        write_reg(REG_END_BLOCK, cut_start + BLK_W'($urandom_range(12)));
        repeat (12) push_random_item();
        repeat (20) stream_q.push_back(8'($urandom));
        send_stream(0);
        wait_idle();

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/mfc_pkg.sv
hdl/mfc_apb_regs.sv
hdl/mfc_mul.sv
hdl/mpeg1_audio_frame_cutter.sv
hdl/mfc_checker.sv
tb/mpeg1_audio_frame_cutter_test.sv
